@@ design/gzhp_pkg.sv @@
// ----------------------------------------------------------------------------
// gzhp_pkg
// Codes and types shared by the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  // parse phase codes
  localparam logic [3:0] PH_MAGIC1  = 4'd0;
  localparam logic [3:0] PH_MAGIC2  = 4'd1;
  localparam logic [3:0] PH_METHOD  = 4'd2;
  localparam logic [3:0] PH_FLAGS   = 4'd3;
  localparam logic [3:0] PH_MTIME   = 4'd4;
  localparam logic [3:0] PH_XFL     = 4'd5;
  localparam logic [3:0] PH_OS      = 4'd6;
  localparam logic [3:0] PH_XLEN    = 4'd7;
  localparam logic [3:0] PH_EXTRA   = 4'd8;
  localparam logic [3:0] PH_NAME    = 4'd9;
  localparam logic [3:0] PH_COMMENT = 4'd10;
  localparam logic [3:0] PH_HCRC    = 4'd11;
  localparam logic [3:0] PH_PAYLOAD = 4'd12;
  localparam logic [3:0] PH_FAILED  = 4'd13;

  // result status codes
  localparam logic [2:0] ST_HEADER     = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_PAYLOAD    = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd3;
  localparam logic [2:0] ST_BAD_METHOD = 3'd4;
  localparam logic [2:0] ST_RESERVED   = 3'd5;
  localparam logic [2:0] ST_TRUNCATED  = 3'd6;

  // stream constants
  localparam logic [7:0] MAGIC1_BYTE   = 8'h1f;
  localparam logic [7:0] MAGIC2_BYTE   = 8'h8b;
  localparam logic [7:0] METHOD_DEFL   = 8'h08;
  localparam logic [7:0] FLAG_HCRC     = 8'h02;
  localparam logic [7:0] FLAG_EXTRA    = 8'h04;
  localparam logic [7:0] FLAG_NAME     = 8'h08;
  localparam logic [7:0] FLAG_COMMENT  = 8'h10;
  localparam logic [7:0] FLAG_RESERVED = 8'he0;

  // outcome of moving to the next optional header section
  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] status;
  } adv_t;

  // first optional section at or after 'from' that the flags ask for
  function automatic adv_t next_section(input logic [3:0] from, input logic [7:0] flags);
    adv_t a;
    a.phase  = PH_PAYLOAD;
    a.status = ST_DONE;
    if (from <= PH_XLEN && (flags & FLAG_EXTRA) != 8'd0) begin
      a.phase  = PH_XLEN;
      a.status = ST_HEADER;
    end else if (from <= PH_NAME && (flags & FLAG_NAME) != 8'd0) begin
      a.phase  = PH_NAME;
      a.status = ST_HEADER;
    end else if (from <= PH_COMMENT && (flags & FLAG_COMMENT) != 8'd0) begin
      a.phase  = PH_COMMENT;
      a.status = ST_HEADER;
    end else if (from <= PH_HCRC && (flags & FLAG_HCRC) != 8'd0) begin
      a.phase  = PH_HCRC;
      a.status = ST_HEADER;
    end
    return a;
  endfunction

endpackage

@@ design/gzip_header_parser.sv @@
// ----------------------------------------------------------------------------
// gzip_header_parser
// Parses a gzip member header one byte per request and passes payload through.
// ----------------------------------------------------------------------------
// Each input request carries one stream byte (in_tdata) or an end-of-stream
// flag (in_tuser) and yields exactly one result request in the next cycle.
// The block takes one request per clock cycle; the only limit is the single
// output register, which is refilled in the same cycle it is emptied, so
// in_tready follows out_tready combinationally when a result is held.
// The result status rides on out_tuser; the captured header fields are shown
// on out_tdata and are meaningful once status "header done" has been seen.
// An error (bad magic, bad method, reserved flag, truncation) is sticky until
// reset: every later request answers with that error code.
// ----------------------------------------------------------------------------
module gzip_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tuser,   // [0] end_mark
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] payload_byte, [15:8] header_flags,
                                  // [47:16] modify_time, [55:48] extra_flags,
                                  // [63:56] os_code
  output logic [2:0]  out_tuser   // [2:0] status
);
  import gzhp_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;
  logic [15:0] extra_left_r, extra_left_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] time_r, time_nxt;
  logic [7:0]  xfl_r, xfl_nxt;
  logic [7:0]  os_r, os_nxt;
  logic [2:0]  error_r, error_nxt;

  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  pay_r, pay_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] extra_dec;
  adv_t        adv;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign extra_dec = extra_left_r - 16'd1;

  // per-byte header and payload step
  always_comb begin
    phase_nxt      = phase_r;
    byte_index_nxt = byte_index_r;
    extra_left_nxt = extra_left_r;
    flags_nxt      = flags_r;
    time_nxt       = time_r;
    xfl_nxt        = xfl_r;
    os_nxt         = os_r;
    error_nxt      = error_r;
    status_nxt     = ST_HEADER;
    pay_nxt        = 8'd0;
    adv            = next_section(PH_XLEN, flags_r);

    if (phase_r >= PH_FAILED) begin
      phase_nxt  = PH_FAILED;
      status_nxt = error_r;
    end else if (in_tuser) begin
      if (phase_r == PH_PAYLOAD) begin
        status_nxt = ST_DONE;
      end else begin
        phase_nxt  = PH_FAILED;
        error_nxt  = ST_TRUNCATED;
        status_nxt = ST_TRUNCATED;
      end
    end else begin
      case (phase_r)
        PH_MAGIC1: begin
          if (b != MAGIC1_BYTE) begin
            phase_nxt  = PH_FAILED;
            error_nxt  = ST_BAD_MAGIC;
            status_nxt = ST_BAD_MAGIC;
          end else begin
            phase_nxt = PH_MAGIC2;
          end
        end
        PH_MAGIC2: begin
          if (b != MAGIC2_BYTE) begin
            phase_nxt  = PH_FAILED;
            error_nxt  = ST_BAD_MAGIC;
            status_nxt = ST_BAD_MAGIC;
          end else begin
            phase_nxt = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (b != METHOD_DEFL) begin
            phase_nxt  = PH_FAILED;
            error_nxt  = ST_BAD_METHOD;
            status_nxt = ST_BAD_METHOD;
          end else begin
            phase_nxt = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flags_nxt = b;
          if ((b & FLAG_RESERVED) != 8'd0) begin
            phase_nxt  = PH_FAILED;
            error_nxt  = ST_RESERVED;
            status_nxt = ST_RESERVED;
          end else begin
            phase_nxt      = PH_MTIME;
            byte_index_nxt = 2'd0;
          end
        end
        PH_MTIME: begin
          // little-endian assembly, one byte lane per index
          case (byte_index_r)
            2'd0:    time_nxt = time_r | {24'd0, b};
            2'd1:    time_nxt = time_r | {16'd0, b, 8'd0};
            2'd2:    time_nxt = time_r | {8'd0, b, 16'd0};
            default: time_nxt = time_r | {b, 24'd0};
          endcase
          byte_index_nxt = byte_index_r + 2'd1;
          if (byte_index_r == 2'd3) begin
            phase_nxt = PH_XFL;
          end
        end
        PH_XFL: begin
          xfl_nxt   = b;
          phase_nxt = PH_OS;
        end
        PH_OS: begin
          os_nxt         = b;
          adv            = next_section(PH_XLEN, flags_r);
          phase_nxt      = adv.phase;
          status_nxt     = adv.status;
          byte_index_nxt = 2'd0;
        end
        PH_XLEN: begin
          if (byte_index_r == 2'd0) begin
            extra_left_nxt = {8'd0, b};
            byte_index_nxt = 2'd1;
          end else begin
            extra_left_nxt = {b, extra_left_r[7:0]};
            byte_index_nxt = 2'd0;
            if ({b, extra_left_r[7:0]} == 16'd0) begin
              adv        = next_section(PH_NAME, flags_r);
              phase_nxt  = adv.phase;
              status_nxt = adv.status;
            end else begin
              phase_nxt = PH_EXTRA;
            end
          end
        end
        PH_EXTRA: begin
          extra_left_nxt = extra_dec;
          if (extra_dec == 16'd0) begin
            adv            = next_section(PH_NAME, flags_r);
            phase_nxt      = adv.phase;
            status_nxt     = adv.status;
            byte_index_nxt = 2'd0;
          end
        end
        PH_NAME: begin
          if (b == 8'd0) begin
            adv            = next_section(PH_COMMENT, flags_r);
            phase_nxt      = adv.phase;
            status_nxt     = adv.status;
            byte_index_nxt = 2'd0;
          end
        end
        PH_COMMENT: begin
          if (b == 8'd0) begin
            adv            = next_section(PH_HCRC, flags_r);
            phase_nxt      = adv.phase;
            status_nxt     = adv.status;
            byte_index_nxt = 2'd0;
          end
        end
        PH_HCRC: begin
          if (byte_index_r == 2'd0) begin
            byte_index_nxt = 2'd1;
          end else begin
            byte_index_nxt = 2'd0;
            phase_nxt      = PH_PAYLOAD;
            status_nxt     = ST_DONE;
          end
        end
        default: begin
          status_nxt = ST_PAYLOAD;
          pay_nxt    = b;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC1;
      byte_index_r <= 2'd0;
      extra_left_r <= 16'd0;
      flags_r      <= 8'd0;
      time_r       <= 32'd0;
      xfl_r        <= 8'd0;
      os_r         <= 8'd0;
      error_r      <= ST_HEADER;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      extra_left_r <= extra_left_nxt;
      flags_r      <= flags_nxt;
      time_r       <= time_nxt;
      xfl_r        <= xfl_nxt;
      os_r         <= os_nxt;
      error_r      <= error_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pay_r    <= pay_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {os_r, xfl_r, time_r, flags_r, pay_r};

`ifndef SYNTHESIS
  // once failed, the parser stays failed
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FAILED |=> phase_r == PH_FAILED)
    else $error("parser left the failed phase");

  // an error result is only shown with the parser in the failed phase
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_BAD_MAGIC || out_tuser == ST_BAD_METHOD ||
     out_tuser == ST_RESERVED || out_tuser == ST_TRUNCATED)) |-> phase_r == PH_FAILED)
    else $error("error result without failed phase");

  // payload results only once the header has ended
  a_pay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_PAYLOAD) |-> phase_r == PH_PAYLOAD)
    else $error("payload result outside payload phase");

  // the byte index reaches two and three only inside the time field, or
  // when a truncation inside the time field parked the parser
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_MTIME && phase_r != PH_FAILED) |-> byte_index_r[1] == 1'b0)
    else $error("byte index out of range");
`endif

endmodule
